// ===== rtl/mpf_pkg.sv =====
// ---------------------------------------------------------------------------
// mpf_pkg: shared types and constants for the publish framer
// Request and response payload structs, controller/datapath command and
// status groups, output select codes.
// ---------------------------------------------------------------------------
package mpf_pkg;

   localparam int DEFAULT_BUFFER_BYTES = 512;
   localparam logic [7:0] PACKET_TYPE_RESET = 8'd48;
   localparam logic [7:0] VARINT_CONT = 8'h80;

   localparam int LEN_W   = 9;   // topic / data length field
   localparam int BODY_W  = 10;  // topic_len + msg_len
   localparam int TOTAL_W = 11;  // remaining length, body + 2

   typedef struct packed {
      logic             func;
      logic [LEN_W-1:0] topic_len;
      logic [LEN_W-1:0] msg_len;
      logic [7:0]       payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       status;
      logic       last;
   } rsp_type;

   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_PAYLOAD = 1'b1;

   // output register source select
   localparam logic [2:0] SEL_TYPE = 3'd0;
   localparam logic [2:0] SEL_VAR0 = 3'd1;
   localparam logic [2:0] SEL_VAR1 = 3'd2;
   localparam logic [2:0] SEL_TLHI = 3'd3;
   localparam logic [2:0] SEL_TLLO = 3'd4;
   localparam logic [2:0] SEL_ERR  = 3'd5;
   localparam logic [2:0] SEL_BYTE = 3'd6;

   typedef struct packed {
      logic       accept;  // request taken this cycle
      logic       emit;    // load output register
      logic [2:0] sel;
   } cmd_type;

   typedef struct packed {
      logic out_free;    // output register can take a byte this cycle
      logic is_start;    // pending request is a start item
      logic fit_err;     // pending start item does not fit the buffer
      logic pass_byte;   // pending payload item produces a byte
      logic two_groups;  // latched remaining length needs two varint bytes
   } status_type;

endpackage

// ===== rtl/mqtt_publish_framer.sv =====
// ---------------------------------------------------------------------------
// mqtt_publish_framer: QoS-0 publish frame builder
// Turns start requests and payload bytes into a framed byte stream.
// ---------------------------------------------------------------------------
// A start request (func 0) produces the packet type byte, the remaining
// length as a one- or two-byte varint and the 16-bit topic length, one
// byte per cycle from the header sequencer while the output register is
// free; a frame larger than BUFFER_BYTES gives one error response instead
// and that packet's payload bytes are swallowed. Payload requests (func 1)
// go through the single output register at one byte per cycle while the
// consumer keeps rsp_ready high; bytes with no open packet are dropped.
// A start request arriving while a packet is open abandons that packet.
// The packet type register may be written at any time through csr_.
module mqtt_publish_framer #(
   parameter int BUFFER_BYTES = mpf_pkg::DEFAULT_BUFFER_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mpf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mpf_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);

   mpf_pkg::cmd_type    cmd;
   mpf_pkg::status_type stat;

   assign csr_ready = 1'b1;

   mpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mpf_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/mpf_ctrl.sv =====
// ---------------------------------------------------------------------------
// mpf_ctrl: framer sequencer
// Accepts requests and steps through the header bytes of a frame,
// one byte per cycle when the output register is free.
// ---------------------------------------------------------------------------
module mpf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mpf_pkg::status_type stat,
   output mpf_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_VAR0 = 3'd1;
   localparam logic [2:0] ST_VAR1 = 3'd2;
   localparam logic [2:0] ST_TLHI = 3'd3;
   localparam logic [2:0] ST_TLLO = 3'd4;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.emit   = 1'b0;
      cmd.sel    = mpf_pkg::SEL_BYTE;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               cmd.accept = 1'b1;
               if (stat.is_start) begin
                  cmd.emit = 1'b1;
                  if (stat.fit_err) begin
                     cmd.sel = mpf_pkg::SEL_ERR;
                  end else begin
                     cmd.sel  = mpf_pkg::SEL_TYPE;
                     state_in = ST_VAR0;
                  end
               end else begin
                  cmd.emit = stat.pass_byte;
                  cmd.sel  = mpf_pkg::SEL_BYTE;
               end
            end
         end
         ST_VAR0: begin
            cmd.sel = mpf_pkg::SEL_VAR0;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = stat.two_groups ? ST_VAR1 : ST_TLHI;
            end
         end
         ST_VAR1: begin
            cmd.sel = mpf_pkg::SEL_VAR1;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_TLHI;
            end
         end
         ST_TLHI: begin
            cmd.sel = mpf_pkg::SEL_TLHI;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_TLLO;
            end
         end
         ST_TLLO: begin
            cmd.sel = mpf_pkg::SEL_TLLO;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/mpf_datapath.sv =====
// ---------------------------------------------------------------------------
// mpf_datapath: framer data registers
// Packet type register, length bookkeeping, fit test and the output
// register that holds one response until it is taken.
// ---------------------------------------------------------------------------
module mpf_datapath #(
   parameter int BUFFER_BYTES = mpf_pkg::DEFAULT_BUFFER_BYTES
) (
   input  logic                clock,
   input  logic                reset,
   input  mpf_pkg::req_type    req_data,
   input  logic                csr_write,
   input  logic [7:0]          csr_data,
   input  mpf_pkg::cmd_type    cmd,
   output mpf_pkg::status_type stat,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mpf_pkg::rsp_type    rsp_data
);

   localparam int BUF_W = $clog2(BUFFER_BYTES + 1);
   localparam int CMP_W = (BUF_W > mpf_pkg::TOTAL_W) ? BUF_W : mpf_pkg::TOTAL_W;
   localparam logic [CMP_W-1:0] BUF_LIMIT = CMP_W'(BUFFER_BYTES);

   logic [7:0]                  packet_type_ff;
   logic [mpf_pkg::BODY_W-1:0]  remaining_ff, remaining_in;
   logic                        dropping_ff, dropping_in;
   logic [mpf_pkg::LEN_W-1:0]   tlen_ff;
   logic [mpf_pkg::TOTAL_W-1:0] total_ff;
   logic                        rsp_valid_ff;
   mpf_pkg::rsp_type            rsp_ff, rsp_in;

   logic [mpf_pkg::BODY_W-1:0]  req_body;
   logic [mpf_pkg::TOTAL_W-1:0] req_total;
   logic [mpf_pkg::TOTAL_W-1:0] req_frame;
   logic                        req_two;
   logic [mpf_pkg::BODY_W-1:0]  rem_dec;

   assign req_body  = {1'b0, req_data.topic_len} + {1'b0, req_data.msg_len};
   assign req_total = {1'b0, req_body} + mpf_pkg::TOTAL_W'(2);
   assign req_two   = |req_total[mpf_pkg::TOTAL_W-1:7];
   // type byte + varint bytes + remaining length
   assign req_frame = req_total + (req_two ? mpf_pkg::TOTAL_W'(3) : mpf_pkg::TOTAL_W'(2));
   assign rem_dec   = remaining_ff - mpf_pkg::BODY_W'(1);

   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.is_start   = (req_data.func == mpf_pkg::FUNC_START);
   assign stat.fit_err    = CMP_W'(req_frame) > BUF_LIMIT;
   assign stat.pass_byte  = (remaining_ff != '0) && !dropping_ff;
   assign stat.two_groups = |total_ff[mpf_pkg::TOTAL_W-1:7];

   always_comb begin
      remaining_in = remaining_ff;
      dropping_in  = dropping_ff;
      if (cmd.accept) begin
         if (req_data.func == mpf_pkg::FUNC_START) begin
            remaining_in = req_body;
            dropping_in  = stat.fit_err && (req_body != '0);
         end else if (remaining_ff == '0) begin
            dropping_in = 1'b0;
         end else begin
            remaining_in = rem_dec;
            if (dropping_ff && rem_dec == '0) begin
               dropping_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      unique case (cmd.sel)
         mpf_pkg::SEL_TYPE: rsp_in.out_byte = packet_type_ff;
         mpf_pkg::SEL_VAR0: begin
            rsp_in.out_byte = {1'b0, total_ff[6:0]}
                            | (stat.two_groups ? mpf_pkg::VARINT_CONT : 8'h00);
         end
         mpf_pkg::SEL_VAR1: begin
            rsp_in.out_byte = 8'(total_ff[mpf_pkg::TOTAL_W-1:7]);
         end
         mpf_pkg::SEL_TLHI: rsp_in.out_byte = {7'b0, tlen_ff[8]};
         mpf_pkg::SEL_TLLO: begin
            rsp_in.out_byte = tlen_ff[7:0];
            // empty body: the topic length closes the frame
            rsp_in.last     = (total_ff == mpf_pkg::TOTAL_W'(2));
         end
         mpf_pkg::SEL_ERR: begin
            rsp_in.status = 1'b1;
            rsp_in.last   = 1'b1;
         end
         mpf_pkg::SEL_BYTE: begin
            rsp_in.out_byte = req_data.payload_byte;
            rsp_in.last     = (remaining_ff == mpf_pkg::BODY_W'(1));
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_type_ff <= mpf_pkg::PACKET_TYPE_RESET;
         remaining_ff   <= '0;
         dropping_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            packet_type_ff <= csr_data;
         end
         remaining_ff <= remaining_in;
         dropping_ff  <= dropping_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_data.func == mpf_pkg::FUNC_START) begin
         tlen_ff  <= req_data.topic_len;
         total_ff <= req_total;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
